@@ design/epl_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epl_pkg
// Shared types and constants for the epipolar line distance core.
// ---------------------------------------------------------------------------
package epl_pkg;

    localparam int FIX_W      = 32;   // point, matrix entry and distance width
    localparam int WIDE_W     = 64;   // line magnitude, radicand and root width
    localparam int SQRT_STEPS = 64;   // one root bit per stage
    localparam int DIV_STEPS  = 32;   // one quotient bit per stage
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PAIR_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAST   = 3'd4;

    // travels alongside the root pipeline and into the range check
    typedef struct packed {
        logic              degen;  // zero line normal
        logic              big;    // |n| already known to be >= 2^64
        logic [WIDE_W-1:0] nabs;   // |l . p2| low 64 bits
    } epl_side_t;

    typedef struct packed {
        logic degen;
        logic sat;
    } epl_flags_t;

endpackage

@@ design/epl_sqrt.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epl_sqrt
// Pipelined integer square root of s * 2^64, one root bit per stage.
// ---------------------------------------------------------------------------
module epl_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [63:0]               s,
    input  epl_pkg::epl_side_t        in_side,
    output logic                      out_valid,
    output logic [63:0]               root,
    output epl_pkg::epl_side_t        out_side
);
    import epl_pkg::*;

    logic                v_reg    [SQRT_STEPS];
    logic [WIDE_W-1:0]   s_reg    [SQRT_STEPS];
    logic [WIDE_W+1:0]   rem_reg  [SQRT_STEPS];
    logic [WIDE_W-1:0]   root_reg [SQRT_STEPS];
    epl_side_t           side_reg [SQRT_STEPS];

    genvar t;
    generate
        for (t = 0; t < SQRT_STEPS; t++) begin : g_step
            logic              v_prev;
            logic [WIDE_W-1:0] s_prev;
            logic [WIDE_W+1:0] rem_prev;
            logic [WIDE_W-1:0] root_prev;
            epl_side_t         side_prev;
            logic [1:0]        pair;
            logic [WIDE_W+3:0] rem_sh;
            logic [WIDE_W+3:0] trial;
            logic              take;
            logic [WIDE_W+1:0] rem_next;
            logic [WIDE_W-1:0] root_next;

            if (t == 0) begin : g_first
                assign v_prev    = in_valid;
                assign s_prev    = s;
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign side_prev = in_side;
            end
            else begin : g_rest
                assign v_prev    = v_reg[t-1];
                assign s_prev    = s_reg[t-1];
                assign rem_prev  = rem_reg[t-1];
                assign root_prev = root_reg[t-1];
                assign side_prev = side_reg[t-1];
            end

            // radicand bits come from s for the upper half, zeros below
            if (t < SQRT_STEPS / 2) begin : g_hi
                assign pair = s_prev[WIDE_W-1-2*t -: 2];
            end
            else begin : g_lo
                assign pair = 2'b00;
            end

            always_comb
            begin
                rem_sh    = {rem_prev, pair};
                trial     = {root_prev, 2'b01};
                take      = (rem_sh >= trial);
                rem_next  = take ? (WIDE_W+2)'(rem_sh - trial) : rem_sh[WIDE_W+1:0];
                root_next = {root_prev[WIDE_W-2:0], take};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[t] <= 1'b0;
                end
                else
                begin
                    v_reg[t] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                s_reg[t]    <= s_prev;
                rem_reg[t]  <= rem_next;
                root_reg[t] <= root_next;
                side_reg[t] <= side_prev;
            end
        end
    endgenerate

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign root      = root_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule

@@ design/epl_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epl_div
// Range check and pipelined restoring division floor(|n| * 2^32 / r).
// ---------------------------------------------------------------------------
module epl_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [63:0]               root,
    input  epl_pkg::epl_side_t        in_side,
    output logic                      out_valid,
    output logic [31:0]               quot,
    output epl_pkg::epl_flags_t       flags
);
    import epl_pkg::*;

    // range check stage
    logic              v0_reg;
    logic [WIDE_W-1:0] r0_reg;
    logic [WIDE_W-1:0] rem0_reg;
    epl_flags_t        f0_reg;
    epl_flags_t        f0_next;

    always_comb
    begin
        f0_next.degen = in_side.degen;
        f0_next.sat   = in_side.big || (in_side.nabs >= root);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg   <= root;
        rem0_reg <= in_side.nabs;
        f0_reg   <= f0_next;
    end

    logic              v_reg   [DIV_STEPS];
    logic [WIDE_W-1:0] r_reg   [DIV_STEPS];
    logic [WIDE_W-1:0] rem_reg [DIV_STEPS];
    logic [FIX_W-1:0]  q_reg   [DIV_STEPS];
    epl_flags_t        f_reg   [DIV_STEPS];

    genvar t;
    generate
        for (t = 0; t < DIV_STEPS; t++) begin : g_step
            logic              v_prev;
            logic [WIDE_W-1:0] r_prev;
            logic [WIDE_W-1:0] rem_prev;
            logic [FIX_W-1:0]  q_prev;
            epl_flags_t        f_prev;
            logic [WIDE_W:0]   rem_sh;
            logic              take;
            logic [WIDE_W-1:0] rem_next;

            if (t == 0) begin : g_first
                assign v_prev   = v0_reg;
                assign r_prev   = r0_reg;
                assign rem_prev = rem0_reg;
                assign q_prev   = '0;
                assign f_prev   = f0_reg;
            end
            else begin : g_rest
                assign v_prev   = v_reg[t-1];
                assign r_prev   = r_reg[t-1];
                assign rem_prev = rem_reg[t-1];
                assign q_prev   = q_reg[t-1];
                assign f_prev   = f_reg[t-1];
            end

            always_comb
            begin
                rem_sh   = {rem_prev, 1'b0};
                take     = (rem_sh >= {1'b0, r_prev});
                rem_next = take ? WIDE_W'(rem_sh - {1'b0, r_prev}) : rem_sh[WIDE_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[t] <= 1'b0;
                end
                else
                begin
                    v_reg[t] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                r_reg[t]   <= r_prev;
                rem_reg[t] <= rem_next;
                q_reg[t]   <= {q_prev[FIX_W-2:0], take};
                f_reg[t]   <= f_prev;
            end
        end
    endgenerate

    assign out_valid = v_reg[DIV_STEPS-1];
    assign quot      = q_reg[DIV_STEPS-1];
    assign flags     = f_reg[DIV_STEPS-1];

endmodule

@@ design/epipolar_line_point_distance_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epipolar_line_point_distance_core
// Distance of p2 from the epipolar line F^T * p1, unsigned Q16.16.
// ---------------------------------------------------------------------------
// Fully pipelined: a new item is taken every clock cycle (busy is always low)
// and its result appears on done after passing through these stages in order:
// six stages form the line, normalise it and build n and s, 64 stages
// resolve the square root one bit each, one stage checks the range and 32
// stages resolve the quotient one bit each, then the output register.
// The receiver cannot stall, so results leave in order, one per item.
// Configuration is taken whenever cfg_valid is high; write only while idle.
module epipolar_line_point_distance_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [epl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                       cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [31:0]                p1_x,
    input  logic signed [31:0]                p1_y,
    input  logic signed [31:0]                p1_w,
    input  logic signed [31:0]                p2_x,
    input  logic signed [31:0]                p2_y,
    input  logic signed [31:0]                p2_w,
    output logic                              done,
    output logic [31:0]                       distance,
    output logic                              degenerate,
    output logic                              saturated
);
    import epl_pkg::*;

    // configuration registers
    logic [63:0] pair_a_reg, pair_b_reg, pair_c_reg, pair_d_reg;
    logic [31:0] last_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_a_reg <= '0;
            pair_b_reg <= '0;
            pair_c_reg <= '0;
            pair_d_reg <= '0;
            last_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PAIR_A: pair_a_reg <= cfg_data;
                REG_PAIR_B: pair_b_reg <= cfg_data;
                REG_PAIR_C: pair_c_reg <= cfg_data;
                REG_PAIR_D: pair_d_reg <= cfg_data;
                REG_LAST:   last_reg   <= cfg_data[31:0];
                default:    ;   // drop writes beyond the list
            endcase
        end
    end

    // matrix entries, fm[i][j] = F(i,j)
    logic signed [FIX_W-1:0] fm [3][3];
    logic signed [FIX_W-1:0] p1 [3];
    logic signed [FIX_W-1:0] p2 [3];

    always_comb
    begin
        fm[0][0] = pair_a_reg[31:0];  fm[0][1] = pair_a_reg[63:32];
        fm[0][2] = pair_b_reg[31:0];  fm[1][0] = pair_b_reg[63:32];
        fm[1][1] = pair_c_reg[31:0];  fm[1][2] = pair_c_reg[63:32];
        fm[2][0] = pair_d_reg[31:0];  fm[2][1] = pair_d_reg[63:32];
        fm[2][2] = last_reg;
        p1[0] = p1_x;  p1[1] = p1_y;  p1[2] = p1_w;
        p2[0] = p2_x;  p2[1] = p2_y;  p2[2] = p2_w;
    end

    logic accept;
    assign accept = start && !busy;

    // ---- stage 1: the nine products, p2 magnitudes
    logic                     v1_reg;
    logic signed [WIDE_W-1:0] prod1_reg [3][3];
    logic [FIX_W-1:0]         p2m1_reg  [3];
    logic                     p2n1_reg  [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod1_reg[i][j] <= WIDE_W'(fm[i][j] * p1[i]);
            end
            p2n1_reg[i] <= p2[i][FIX_W-1];
            p2m1_reg[i] <= p2[i][FIX_W-1] ? FIX_W'(-p2[i]) : p2[i];
        end
    end

    // ---- stage 2: line l = F^T p1 as sign and magnitude
    logic              v2_reg;
    logic [WIDE_W-1:0] lm2_reg   [3];
    logic              ln2_reg   [3];
    logic [FIX_W-1:0]  p2m2_reg  [3];
    logic              p2n2_reg  [3];
    logic signed [WIDE_W+1:0] lsum_next [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lsum_next[j] = (WIDE_W+2)'(prod1_reg[0][j]) + (WIDE_W+2)'(prod1_reg[1][j])
                         + (WIDE_W+2)'(prod1_reg[2][j]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            ln2_reg[j]  <= lsum_next[j][WIDE_W+1];
            lm2_reg[j]  <= lsum_next[j][WIDE_W+1] ? WIDE_W'(-lsum_next[j])
                                                  : lsum_next[j][WIDE_W-1:0];
            p2m2_reg[j] <= p2m1_reg[j];
            p2n2_reg[j] <= p2n1_reg[j];
        end
    end

    // ---- stage 3: normalising shift from the larger normal component
    logic              v3_reg;
    logic [WIDE_W-1:0] lm3_reg  [3];
    logic              sgn3_reg [3];
    logic [FIX_W-1:0]  p2m3_reg [3];
    logic [5:0]        k3_reg;
    logic              degen3_reg;
    logic [WIDE_W-1:0] m_next;
    logic [5:0]        hb_next;
    logic [5:0]        k_next;

    always_comb
    begin
        m_next  = (lm2_reg[0] > lm2_reg[1]) ? lm2_reg[0] : lm2_reg[1];
        hb_next = '0;
        for (int i = 0; i < WIDE_W; i++)
        begin
            if (m_next[i])
            begin
                hb_next = 6'(i);
            end
        end
        k_next = (hb_next >= 6'(FIX_W - 1)) ? 6'(hb_next - 6'(FIX_W - 2)) : 6'd0;
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            lm3_reg[j]  <= lm2_reg[j];
            sgn3_reg[j] <= ln2_reg[j] ^ p2n2_reg[j];
            p2m3_reg[j] <= p2m2_reg[j];
        end
        k3_reg     <= k_next;
        degen3_reg <= (m_next == '0);
    end

    // ---- stage 4: shift the line down
    logic              v4_reg;
    logic [FIX_W-2:0]  sm0_4_reg, sm1_4_reg;
    logic [WIDE_W-1:0] sm2_4_reg;
    logic              sgn4_reg [3];
    logic [FIX_W-1:0]  p2m4_reg [3];
    logic              degen4_reg;

    always_ff @(posedge clk)
    begin
        sm0_4_reg  <= (FIX_W-1)'(lm3_reg[0] >> k3_reg);
        sm1_4_reg  <= (FIX_W-1)'(lm3_reg[1] >> k3_reg);
        sm2_4_reg  <= lm3_reg[2] >> k3_reg;
        for (int j = 0; j < 3; j++)
        begin
            sgn4_reg[j] <= sgn3_reg[j];
            p2m4_reg[j] <= p2m3_reg[j];
        end
        degen4_reg <= degen3_reg;
    end

    // ---- stage 5: partial products
    logic              v5_reg;
    logic [62:0]       pp0_5_reg, pp1_5_reg;
    logic [63:0]       pp2lo_5_reg, pp2hi_5_reg;
    logic [61:0]       sq0_5_reg, sq1_5_reg;
    logic              sgn5_reg [3];
    logic              degen5_reg;

    always_ff @(posedge clk)
    begin
        pp0_5_reg   <= 63'(sm0_4_reg) * 63'(p2m4_reg[0]);
        pp1_5_reg   <= 63'(sm1_4_reg) * 63'(p2m4_reg[1]);
        pp2lo_5_reg <= 64'(sm2_4_reg[31:0]) * 64'(p2m4_reg[2]);
        pp2hi_5_reg <= 64'(sm2_4_reg[63:32]) * 64'(p2m4_reg[2]);
        sq0_5_reg   <= 62'(sm0_4_reg) * 62'(sm0_4_reg);
        sq1_5_reg   <= 62'(sm1_4_reg) * 62'(sm1_4_reg);
        for (int j = 0; j < 3; j++)
        begin
            sgn5_reg[j] <= sgn4_reg[j];
        end
        degen5_reg <= degen4_reg;
    end

    // ---- stage 6: n = l . p2 and s = a^2 + b^2
    logic              v6_reg;
    logic [WIDE_W-1:0] s6_reg;
    epl_side_t         side6_reg;
    logic [95:0]       t2_next;
    logic [97:0]       e_next [3];
    logic [97:0]       n_next;
    logic [97:0]       nabs_next;

    always_comb
    begin
        t2_next   = {pp2hi_5_reg, 32'd0} + 96'(pp2lo_5_reg);
        e_next[0] = 98'(pp0_5_reg);
        e_next[1] = 98'(pp1_5_reg);
        e_next[2] = 98'(t2_next);
        n_next    = '0;
        for (int j = 0; j < 3; j++)
        begin
            n_next = n_next + (sgn5_reg[j] ? 98'(-e_next[j]) : e_next[j]);
        end
        nabs_next = n_next[97] ? 98'(-n_next) : n_next;
    end

    always_ff @(posedge clk)
    begin
        s6_reg          <= 64'(sq0_5_reg) + 64'(sq1_5_reg);
        side6_reg.degen <= degen5_reg;
        side6_reg.big   <= |nabs_next[97:64];
        side6_reg.nabs  <= nabs_next[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // ---- square root and division pipelines
    logic              sq_valid;
    logic [WIDE_W-1:0] sq_root;
    epl_side_t         sq_side;
    logic              dv_valid;
    logic [FIX_W-1:0]  dv_quot;
    epl_flags_t        dv_flags;

    epl_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .s         (s6_reg),
        .in_side   (side6_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    epl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .flags     (dv_flags)
    );

    // ---- output register
    logic             done_reg;
    logic [FIX_W-1:0] distance_reg;
    logic             degen_reg;
    logic             sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= (dv_flags.degen || dv_flags.sat) ? '1 : dv_quot;
        degen_reg    <= dv_flags.degen;
        sat_reg      <= dv_flags.sat && !dv_flags.degen;
    end

    assign done       = done_reg;
    assign distance   = distance_reg;
    assign degenerate = degen_reg;
    assign saturated  = sat_reg;

endmodule
